/* rtl/cte_pkg.sv */
package cte_pkg;

    // Function codes carried by an input item
    typedef enum logic [1:0] {
        FUNC_LOAD  = 2'd0,
        FUNC_READ  = 2'd1,
        FUNC_CLEAR = 2'd2
    } func_t;

    // Item kind after classification in the front end
    typedef enum logic [1:0] {
        KIND_LOAD,
        KIND_READ,
        KIND_CLEAR,
        KIND_NOP
    } kind_t;

    // Result status codes
    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_DROPPED = 2'd1,
        ST_RANGE   = 2'd2
    } status_t;

    // Back-end sequencer states
    typedef enum logic [1:0] {
        S_IDLE,
        S_LOOKUP,
        S_SLOT
    } state_t;

    // Raw double pattern of 1.0
    localparam logic [63:0] ONE_BITS = 64'h3FF0_0000_0000_0000;

    typedef struct packed {
        logic [1:0]  func;
        logic [15:0] row_index;
        logic [7:0]  column_index;
        logic [63:0] entry_value;
        logic [3:0]  slot;
    } item_t;

    typedef struct packed {
        logic [15:0] out_row;
        logic [63:0] out_value;
        logic        is_real_entry;
        logic [4:0]  widest_column;
        logic [1:0]  status;
    } result_t;

    // Classified item passed from front to back
    typedef struct packed {
        kind_t       kind;
        logic        col_ok;
        logic [15:0] row;
        logic [7:0]  column;
        logic [63:0] value;
        logic [3:0]  slot;
    } op_t;

endpackage

/* rtl/cte_ram.sv */
module cte_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write one word, read one word with registered data
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

/* rtl/cte_front.sv */
module cte_front
    import cte_pkg::*;
#(
    parameter int COLUMNS = 256
) (
    input  logic  clk,
    input  logic  rst_n,
    input  logic  start,
    output logic  busy,
    input  item_t item,
    output logic  q_valid,
    input  logic  q_pop,
    output op_t   q_op
);

    localparam int QDEPTH = 2;
    localparam logic [16:0] COL_LIMIT = 17'(COLUMNS);

    op_t        fifo_reg [QDEPTH];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       push;
    op_t        op_in;

    // Classify the incoming item
    always_comb
    begin
        op_in.row    = item.row_index;
        op_in.column = item.column_index;
        op_in.value  = item.entry_value;
        op_in.slot   = item.slot;
        op_in.col_ok = 17'(item.column_index) < COL_LIMIT;
        unique case (item.func)
            FUNC_LOAD:  op_in.kind = KIND_LOAD;
            FUNC_READ:  op_in.kind = KIND_READ;
            FUNC_CLEAR: op_in.kind = KIND_CLEAR;
            default:    op_in.kind = KIND_NOP;
        endcase
    end

    assign busy    = count_reg == 2'(QDEPTH);
    assign push    = start && !busy;
    assign q_valid = count_reg != '0;
    assign q_op    = fifo_reg[rd_ptr_reg];

    // Advance pointers and occupancy
    always_comb
    begin
        wr_ptr_next = push  ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = q_pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !q_pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (!push && q_pop)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the classified item
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            fifo_reg[wr_ptr_reg] <= op_in;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= 2'(QDEPTH))
        else $error("queue occupancy beyond depth");

    a_accept_fills: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> count_reg != '0)
        else $error("accepted item missing from queue");

endmodule

/* rtl/cte_back.sv */
module cte_back
    import cte_pkg::*;
#(
    parameter int COLUMNS          = 256,
    parameter int SLOTS_PER_COLUMN = 16,
    parameter int ROW_BITS         = 16
) (
    input  logic    clk,
    input  logic    rst_n,
    input  logic    pattern_only,
    input  logic    q_valid,
    output logic    q_pop,
    input  op_t     q_op,
    output logic    done,
    output result_t result
);

    localparam int COL_W  = $clog2(COLUMNS);
    localparam int FILL_W = $clog2(SLOTS_PER_COLUMN + 1);
    localparam int SLOT_W = (SLOTS_PER_COLUMN > 1) ? $clog2(SLOTS_PER_COLUMN) : 1;
    localparam int DEPTH  = COLUMNS * SLOTS_PER_COLUMN;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int DATA_W = ROW_BITS + 64;
    localparam int CMP_W  = FILL_W + 4;

    state_t              state_reg, state_next;
    op_t                 op_reg;
    logic [FILL_W-1:0]   widest_reg, widest_next;
    logic [COLUMNS-1:0]  valid_reg;
    logic                real_reg, real_next;
    logic                done_reg, done_next;
    result_t             res_reg, res_next;

    logic                cnt_re, cnt_we;
    logic [FILL_W-1:0]   cnt_rdata, cnt_wdata;
    logic                slot_re, slot_we;
    logic [ADDR_W-1:0]   slot_raddr, slot_waddr;
    logic [DATA_W-1:0]   slot_rdata, slot_wdata;

    logic [COL_W-1:0]    col_idx;
    logic [FILL_W-1:0]   fill, fill_inc;
    logic                in_widest, need_slot, clear_all, set_valid;

    function automatic logic [ADDR_W-1:0] slot_addr(input logic [COL_W-1:0] c,
                                                   input logic [SLOT_W-1:0] s);
        return ADDR_W'(c) * ADDR_W'(SLOTS_PER_COLUMN) + ADDR_W'(s);
    endfunction

    // Per-column entry counts
    cte_ram #(.WIDTH(FILL_W), .DEPTH(COLUMNS)) u_cnt_ram (
        .clk   (clk),
        .we    (cnt_we),
        .waddr (col_idx),
        .wdata (cnt_wdata),
        .re    (cnt_re),
        .raddr (COL_W'(q_op.column)),
        .rdata (cnt_rdata)
    );

    // Slot store: row index over raw value
    cte_ram #(.WIDTH(DATA_W), .DEPTH(DEPTH)) u_slot_ram (
        .clk   (clk),
        .we    (slot_we),
        .waddr (slot_waddr),
        .wdata (slot_wdata),
        .re    (slot_re),
        .raddr (slot_raddr),
        .rdata (slot_rdata)
    );

    // Decode the looked-up column
    assign col_idx   = COL_W'(op_reg.column);
    assign fill      = valid_reg[col_idx] ? cnt_rdata : '0;
    assign fill_inc  = fill + FILL_W'(1);
    assign in_widest = CMP_W'(op_reg.slot) < CMP_W'(widest_reg);
    assign need_slot = (op_reg.kind == KIND_READ) && op_reg.col_ok && in_widest
                       && (fill != '0);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (q_valid)
                begin
                    state_next = S_LOOKUP;
                end
            end
            S_LOOKUP: state_next = need_slot ? S_SLOT : S_IDLE;
            S_SLOT:   state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    // Outputs and datapath control
    always_comb
    begin
        q_pop       = 1'b0;
        cnt_re      = 1'b0;
        cnt_we      = 1'b0;
        cnt_wdata   = fill_inc;
        slot_we     = 1'b0;
        slot_re     = 1'b0;
        slot_raddr  = slot_addr(col_idx, SLOT_W'(op_reg.slot));
        slot_waddr  = slot_addr(col_idx, SLOT_W'(fill));
        slot_wdata  = {ROW_BITS'(op_reg.row), pattern_only ? ONE_BITS : op_reg.value};
        widest_next = widest_reg;
        clear_all   = 1'b0;
        set_valid   = 1'b0;
        real_next   = real_reg;
        done_next   = 1'b0;
        res_next.out_row       = '0;
        res_next.out_value     = '0;
        res_next.is_real_entry = 1'b0;
        res_next.widest_column = '0;
        res_next.status        = ST_OK;
        unique case (state_reg)
            S_IDLE:
            begin
                q_pop  = q_valid;
                cnt_re = q_valid;
            end
            S_LOOKUP:
            begin
                done_next = !need_slot;
                unique case (op_reg.kind)
                    KIND_LOAD:
                    begin
                        if (!op_reg.col_ok || fill >= FILL_W'(SLOTS_PER_COLUMN))
                        begin
                            res_next.status = ST_DROPPED;
                        end
                        else
                        begin
                            cnt_we    = 1'b1;
                            slot_we   = 1'b1;
                            set_valid = 1'b1;
                            if (fill_inc > widest_reg)
                            begin
                                widest_next = fill_inc;
                            end
                        end
                    end
                    KIND_READ:
                    begin
                        if (!op_reg.col_ok || !in_widest)
                        begin
                            res_next.status = ST_RANGE;
                        end
                        else if (need_slot)
                        begin
                            slot_re = 1'b1;
                            if (CMP_W'(op_reg.slot) < CMP_W'(fill))
                            begin
                                real_next = 1'b1;
                            end
                            else
                            begin
                                // Padding repeats the column's last stored row
                                real_next  = 1'b0;
                                slot_raddr = slot_addr(col_idx, SLOT_W'(fill - FILL_W'(1)));
                            end
                        end
                    end
                    KIND_CLEAR:
                    begin
                        clear_all   = 1'b1;
                        widest_next = '0;
                    end
                    default:
                    begin
                    end
                endcase
            end
            S_SLOT:
            begin
                done_next              = 1'b1;
                res_next.out_row       = 16'(slot_rdata[DATA_W-1:64]);
                res_next.out_value     = real_reg ? slot_rdata[63:0] : 64'd0;
                res_next.is_real_entry = real_reg;
            end
            default:
            begin
            end
        endcase
        res_next.widest_column = 5'(widest_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            widest_reg <= '0;
            valid_reg  <= '0;
            done_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            widest_reg <= widest_next;
            done_reg   <= done_next;
            if (clear_all)
            begin
                valid_reg <= '0;
            end
            else if (set_valid)
            begin
                valid_reg[col_idx] <= 1'b1;
            end
        end
    end

    // Hold the current item and the result payload
    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            op_reg <= q_op;
        end
        real_reg <= real_next;
        res_reg  <= res_next;
    end

    assign done   = done_reg;
    assign result = res_reg;

    a_widest_bound: assert property (@(posedge clk) disable iff (!rst_n)
        widest_reg <= FILL_W'(SLOTS_PER_COLUMN))
        else $error("widest count beyond slots per column");

    a_real_ok: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg && res_reg.is_real_entry |-> res_reg.status == ST_OK)
        else $error("real entry reported with error status");

    a_done_src: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(state_reg == S_LOOKUP || state_reg == S_SLOT))
        else $error("result strobe without a finished lookup");

endmodule

/* rtl/coo_to_columnwise_ellpack_top.sv */
// A result strobes on done once its item has left the queue and passed S_LOOKUP, plus S_SLOT
// for a read that fetches a slot. The back end pops a new item only from S_IDLE, after the
// count-RAM lookup and any slot-RAM read; a 2-entry queue decouples the start side.
// busy is high only while that queue is full; results cannot be stalled.
// Reset: all column counts read as zero (per-column valid flops), widest count and
// pattern_only clear; slot contents are undefined until written.
module coo_to_columnwise_ellpack_top
    import cte_pkg::*;
#(
    parameter int COLUMNS          = 256,
    parameter int SLOTS_PER_COLUMN = 16,
    parameter int ROW_BITS         = 16
) (
    input  logic    clk,
    input  logic    rst_n,
    input  logic    start,
    output logic    busy,
    input  item_t   item,
    input  logic    cfg_we,
    input  logic    cfg_data,
    output logic    done,
    output result_t result
);

    logic pattern_only_reg;
    logic q_valid;
    logic q_pop;
    op_t  q_op;

    // Configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_only_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            pattern_only_reg <= cfg_data;
        end
    end

    cte_front #(.COLUMNS(COLUMNS)) u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .item    (item),
        .q_valid (q_valid),
        .q_pop   (q_pop),
        .q_op    (q_op)
    );

    cte_back #(
        .COLUMNS          (COLUMNS),
        .SLOTS_PER_COLUMN (SLOTS_PER_COLUMN),
        .ROW_BITS         (ROW_BITS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .pattern_only (pattern_only_reg),
        .q_valid      (q_valid),
        .q_pop        (q_pop),
        .q_op         (q_op),
        .done         (done),
        .result       (result)
    );

endmodule

/* tb/ellpack_checker.sv */
module ellpack_checker
    import cte_pkg::*;
#(
    parameter int COLUMNS          = 256,
    parameter int SLOTS_PER_COLUMN = 16
) (
    input  logic    clk,
    input  logic    rst_n,
    input  logic    start,
    input  logic    busy,
    input  item_t   item,
    input  logic    cfg_we,
    input  logic    cfg_data,
    input  logic    done,
    input  result_t result,
    output int      fail_count,
    output int      outstanding
);

    // Shadow copy of the column store
    logic        ones_only;
    logic [4:0]  col_fill [COLUMNS];
    logic [4:0]  widest_fill;
    logic [15:0] slot_row [COLUMNS][SLOTS_PER_COLUMN];
    logic [63:0] slot_value [COLUMNS][SLOTS_PER_COLUMN];
    result_t     slot_answers [$];

    // Print one line per error and count it
    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("ERROR at %0t: %s got %0h, expected %0h", $time, what, got, want);
        fail_count++;
    endtask

    // Apply one item to the shadow store and work out its result
    task automatic ellpack_apply(input item_t it, output result_t r);
        logic [7:0] c;
        logic [4:0] f;
        logic [4:0] nf;
        r  = '0;
        c  = it.column_index;
        f  = col_fill[c];
        nf = f + 5'd1;
        case (it.func)
            FUNC_LOAD: begin
                // drop the entry when its column has no free slot
                if (f >= 5'(SLOTS_PER_COLUMN)) begin
                    r.status = ST_DROPPED;
                end else begin
                    slot_row[c][f[3:0]]   = it.row_index;
                    slot_value[c][f[3:0]] = ones_only ? ONE_BITS : it.entry_value;
                    col_fill[c] = nf;
                    if (nf > widest_fill)
                        widest_fill = nf;
                end
            end
            FUNC_READ: begin
                // real entry below the fill, padding up to the widest column
                if ({1'b0, it.slot} >= widest_fill) begin
                    r.status = ST_RANGE;
                end else if ({1'b0, it.slot} < f) begin
                    r.out_row       = slot_row[c][it.slot];
                    r.out_value     = slot_value[c][it.slot];
                    r.is_real_entry = 1'b1;
                end else if (f != 5'd0) begin
                    r.out_row = slot_row[c][f[3:0] - 4'd1];
                end
            end
            FUNC_CLEAR: begin
                foreach (col_fill[i])
                    col_fill[i] = '0;
                widest_fill = '0;
            end
            default: ;
        endcase
        r.widest_column = widest_fill;
    endtask

    // Compare each result with the oldest expectation, then queue new items
    always @(posedge clk or negedge rst_n) begin : watch
        result_t want;
        if (!rst_n) begin
            ones_only   = 1'b0;
            widest_fill = '0;
            foreach (col_fill[i])
                col_fill[i] = '0;
            slot_answers.delete();
            fail_count  = 0;
            outstanding <= 0;
        end else begin
            if (done) begin
                if (slot_answers.size() == 0) begin
                    report_mismatch("result with no item pending", 64'(result.out_row), '0);
                end else begin
                    want = slot_answers.pop_front();
                    if (result.out_row !== want.out_row)
                        report_mismatch("out_row", 64'(result.out_row), 64'(want.out_row));
                    if (result.out_value !== want.out_value)
                        report_mismatch("out_value", result.out_value, want.out_value);
                    if (result.is_real_entry !== want.is_real_entry)
                        report_mismatch("is_real_entry", 64'(result.is_real_entry),
                                        64'(want.is_real_entry));
                    if (result.widest_column !== want.widest_column)
                        report_mismatch("widest_column", 64'(result.widest_column),
                                        64'(want.widest_column));
                    if (result.status !== want.status)
                        report_mismatch("status", 64'(result.status), 64'(want.status));
                end
            end
            if (cfg_we)
                ones_only = cfg_data;
            if (start && !busy) begin
                ellpack_apply(item, want);
                slot_answers.push_back(want);
            end
            outstanding <= slot_answers.size();
        end
    end

endmodule

/* tb/coo_to_columnwise_ellpack_top_tb.sv */
module coo_to_columnwise_ellpack_top_tb;
    import cte_pkg::*;

    localparam logic [1:0] FUNC_UNUSED    = 2'd3;
    localparam int         WATCHDOG_LIMIT = 1000;
    localparam int         PHASE_ITEMS    = 135;

    logic       clk      = 1'b0;
    logic       rst_n    = 1'b0;
    logic       start    = 1'b0;
    item_t      item     = '0;
    logic       cfg_we   = 1'b0;
    logic       cfg_data = 1'b0;
    logic       busy;
    logic       done;
    result_t    result;
    int         fail_count;
    int         outstanding;
    int         stall_cycles = 0;
    logic [7:0] hot_cols [4];
    bit         no_idle = 1'b0;

    always #4 clk = ~clk;

    coo_to_columnwise_ellpack_top dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .item     (item),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .done     (done),
        .result   (result)
    );

    ellpack_checker chk (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .item        (item),
        .cfg_we      (cfg_we),
        .cfg_data    (cfg_data),
        .done        (done),
        .result      (result),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    // End the run when nothing moves for too long
    always @(posedge clk) begin
        if ((start && !busy) || done)
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    function automatic item_t make_item(input logic [1:0] fn, input logic [15:0] row,
                                        input logic [7:0] col, input logic [63:0] val,
                                        input logic [3:0] slot);
        item_t it;
        it.func         = fn;
        it.row_index    = row;
        it.column_index = col;
        it.entry_value  = val;
        it.slot         = slot;
        return it;
    endfunction

    // Mostly short gaps, a few long ones, none inside a burst
    function automatic int idle_gap();
        int roll;
        if (no_idle)
            return 0;
        roll = $urandom_range(0, 99);
        if (roll < 45)
            return 0;
        if (roll < 90)
            return $urandom_range(1, 3);
        return $urandom_range(6, 30);
    endfunction

    // Hold start until the item is taken, then idle for a random gap (possibly none)
    task automatic send_item(input item_t it);
        int gap;
        start <= 1'b1;
        item  <= it;
        do @(posedge clk); while (busy);
        gap = idle_gap();
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic write_pattern(input logic v);
        cfg_we   <= 1'b1;
        cfg_data <= v;
        @(posedge clk);
        cfg_we   <= 1'b0;
    endtask

    // Wait for every result, then let the pipeline settle
    task automatic drain();
        start <= 1'b0;
        do @(posedge clk); while (outstanding != 0);
        repeat (4) @(posedge clk);
    endtask

    // Loads crowd a few columns so they fill up and overflow between clears
    function automatic item_t random_item();
        int         roll;
        int         pick;
        logic [1:0] fn;
        logic [7:0] col;
        roll = $urandom_range(0, 99);
        pick = $urandom_range(0, 9);
        if (roll < 52)
            fn = FUNC_LOAD;
        else if (roll < 92)
            fn = FUNC_READ;
        else if (roll < 94)
            fn = FUNC_CLEAR;
        else
            fn = FUNC_UNUSED;
        if (pick < 5)
            col = hot_cols[0];
        else if (pick < 8)
            col = hot_cols[$urandom_range(1, 3)];
        else
            col = 8'($urandom_range(0, 255));
        return make_item(fn, 16'($urandom_range(0, 65535)), col, {$urandom, $urandom},
                         4'($urandom_range(0, 15)));
    endfunction

    initial begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        write_pattern(1'b0);

        // Directed: empty read, fill a column past full, padding, unused code, clear
        send_item(make_item(FUNC_READ, 16'h0, 8'h00, 64'h0, 4'h0));
        send_item(make_item(FUNC_LOAD, 16'hFFFF, 8'hFF, '1, 4'hF));
        for (int k = 1; k < 16; k++)
            send_item(make_item(FUNC_LOAD, 16'(k), 8'hFF,
                                (k == 1) ? 64'h0 : {$urandom, $urandom}, 4'(k)));
        send_item(make_item(FUNC_LOAD, 16'hAAAA, 8'hFF, 64'h1, 4'h0));
        send_item(make_item(FUNC_LOAD, 16'h1234, 8'h00, 64'h0, 4'h0));
        send_item(make_item(FUNC_READ, 16'h0, 8'hFF, 64'h0, 4'hF));
        send_item(make_item(FUNC_READ, 16'h0, 8'h00, 64'h0, 4'hF));
        send_item(make_item(FUNC_READ, 16'h0, 8'h07, 64'h0, 4'h4));
        send_item(make_item(FUNC_UNUSED, 16'hFFFF, 8'hFF, '1, 4'hF));
        send_item(make_item(FUNC_CLEAR, 16'h0, 8'h00, 64'h0, 4'h0));
        send_item(make_item(FUNC_READ, 16'h0, 8'hFF, 64'h0, 4'h0));
        drain();

        // Random phases, each under its own value setting
        for (int ph = 0; ph < 4; ph++) begin
            foreach (hot_cols[i])
                hot_cols[i] = 8'($urandom_range(0, 255));
            write_pattern((ph == 3) ? 1'($urandom_range(0, 1)) : ((ph % 2) == 0));
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                no_idle = (n >= 40 && n < 70);
                send_item(random_item());
            end
            drain();
        end

        if (fail_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
